// ===== rtl/core/gasa_pkg.sv =====
// Package for the glyph atlas shelf allocator.
// Holds the atlas geometry, the derived widths, the status codes and the cache record type.
// No dependencies; every other file imports it.
package gasa_pkg;

  // Atlas geometry and the size of the code table.
  localparam int TEXTURE_SIZE = 1024;
  localparam int MAX_PAGES    = 8;
  localparam int CODE_SPACE   = 65536;

  // Field widths fixed by the interface.
  localparam int CODE_W   = 16;
  localparam int DIM_W    = 10;
  localparam int POS_W    = 10;
  localparam int PAGE_W   = 3;
  localparam int MARGIN_W = 4;

  // Derived widths: cursors hold up to the texture size, sums get two spare bits.
  localparam int ADDR_W = $clog2(CODE_SPACE);
  localparam int CUR_W  = $clog2(TEXTURE_SIZE) + 1;
  localparam int SUM_W  = CUR_W + 2;

  // Glyph margin after reset.
  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(2);

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_HIT       = 2'd0,
    STAT_PLACED    = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_t;

  // One entry of the code table; the valid bit travels with the record.
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
  } rec_t;

endpackage

// ===== rtl/core/glyph_atlas_shelf_allocator_unit.sv =====
// Top level of the glyph atlas shelf allocator: code table memory, packing cursor
// and result register. Depends on gasa_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request beat: a character code and
//   the measured glyph width and height. Result channel (out_valid/out_ready) returns
//   exactly one beat per request: status, page, position and size of the glyph.
//   Configuration: cfg_we writes cfg_glyph_margin in the same cycle, no handshake.
//   The request is registered into the lookup state; the result is registered into the
//   output register once that register is free. The code table is a single memory with a
//   registered read; a request reads its entry when it is accepted and writes the new
//   record and the cursors back in the lookup state, so requests are processed one at a time.
//   Reset: rst_n (synchronous, active low) sets the margin to 2, the cursors to the
//   margin and the page to 0, then a clearing pass writes every one of the 65536 table
//   entries as invalid, one per cycle. in_ready stays low until the pass ends.
//   Stall: a finished result waits in the output register while out_ready is low. The
//   next request is still accepted and read; its write-back and cursor update wait
//   until the output register is free.
module glyph_atlas_shelf_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gasa_pkg::CODE_W-1:0]   in_char_code,
  input  logic [gasa_pkg::DIM_W-1:0]    in_glyph_width,
  input  logic [gasa_pkg::DIM_W-1:0]    in_glyph_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [gasa_pkg::PAGE_W-1:0]   out_page_index,
  output logic [gasa_pkg::POS_W-1:0]    out_pos_x,
  output logic [gasa_pkg::POS_W-1:0]    out_pos_y,
  output logic [gasa_pkg::DIM_W-1:0]    out_out_width,
  output logic [gasa_pkg::DIM_W-1:0]    out_out_height,
  input  logic                          cfg_we,
  input  logic [gasa_pkg::MARGIN_W-1:0] cfg_glyph_margin
);
  import gasa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  localparam logic [SUM_W-1:0] TEX_LIM = SUM_W'(TEXTURE_SIZE);

  // Control state.
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [MARGIN_W-1:0] margin_r;
  logic [CUR_W-1:0]    cur_x_r, cur_x_nxt;
  logic [CUR_W-1:0]    cur_y_r, cur_y_nxt;
  logic [CUR_W-1:0]    row_h_r, row_h_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request and result payload.
  logic [ADDR_W-1:0]   code_r;
  logic                in_range_r;
  logic [DIM_W-1:0]    w_r, h_r;
  rec_t                rd_data_r;
  status_t             res_status;
  logic [PAGE_W-1:0]   res_page;
  logic [POS_W-1:0]    res_x, res_y;
  logic [DIM_W-1:0]    res_w, res_h;
  logic [1:0]          out_status_r;
  logic [PAGE_W-1:0]   out_page_r;
  logic [POS_W-1:0]    out_x_r, out_y_r;
  logic [DIM_W-1:0]    out_w_r, out_h_r;

  // Memory control.
  rec_t                mem [CODE_SPACE];
  logic                accept, commit, place;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  rec_t                mem_wdata;

  assign accept = in_valid && in_ready;
  assign commit = (state_r == S_LOOK) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  // Code table: read on accept, written by the clearing pass or by a placement.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[in_char_code[ADDR_W-1:0]];
    end
  end

  // Latch the request fields for the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r     <= in_char_code[ADDR_W-1:0];
      in_range_r <= (32'(in_char_code) < CODE_SPACE);
      w_r        <= in_glyph_width;
      h_r        <= in_glyph_height;
    end
  end

  // Shelf placement and result selection.
  always_comb begin
    logic [SUM_W-1:0] m, cw, ch, x1, y1, rh1, x2, y2, rh2;
    logic             too_big, wrap, new_page, exhausted;
    m  = SUM_W'(margin_r);
    cw = SUM_W'(w_r) + m;
    ch = SUM_W'(h_r) + m;
    too_big = ((m + cw) > TEX_LIM) || ((m + ch) > TEX_LIM);
    wrap = (SUM_W'(cur_x_r) + cw) > TEX_LIM;
    x1  = wrap ? m : SUM_W'(cur_x_r);
    y1  = wrap ? (SUM_W'(cur_y_r) + SUM_W'(row_h_r)) : SUM_W'(cur_y_r);
    rh1 = wrap ? m : SUM_W'(row_h_r);
    new_page  = (y1 + ch) > TEX_LIM;
    exhausted = new_page && ((32'(page_r) + 1) >= MAX_PAGES);
    x2  = new_page ? m : x1;
    y2  = new_page ? m : y1;
    rh2 = new_page ? m : rh1;

    res_status = STAT_TOO_LARGE;
    res_page   = '0;
    res_x      = '0;
    res_y      = '0;
    res_w      = '0;
    res_h      = '0;
    place      = 1'b0;
    if (in_range_r && rd_data_r.valid) begin
      res_status = STAT_HIT;
      res_page   = rd_data_r.page;
      res_x      = rd_data_r.x;
      res_y      = rd_data_r.y;
      res_w      = rd_data_r.w;
      res_h      = rd_data_r.h;
    end else if (in_range_r && !too_big) begin
      if (exhausted) begin
        res_status = STAT_EXHAUSTED;
      end else begin
        res_status = STAT_PLACED;
        res_page   = new_page ? (page_r + PAGE_W'(1)) : page_r;
        res_x      = POS_W'(x2);
        res_y      = POS_W'(y2);
        res_w      = w_r;
        res_h      = h_r;
        place      = 1'b1;
      end
    end

    // Cursor update, applied only on a committed placement.
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    row_h_nxt = row_h_r;
    page_nxt  = page_r;
    if (commit && place) begin
      cur_x_nxt = CUR_W'(x2 + cw);
      cur_y_nxt = CUR_W'(y2);
      row_h_nxt = (ch > rh2) ? CUR_W'(ch) : CUR_W'(rh2);
      page_nxt  = res_page;
    end
  end

  // Memory write select: clearing sweep or the new record.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = code_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end else if (commit && place) begin
      mem_we    = 1'b1;
      mem_wdata = '{valid: 1'b1, page: res_page, x: res_x, y: res_y, w: res_w, h: res_h};
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(CODE_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      margin_r    <= MARGIN_RST;
      cur_x_r     <= CUR_W'(MARGIN_RST);
      cur_y_r     <= CUR_W'(MARGIN_RST);
      row_h_r     <= CUR_W'(MARGIN_RST);
      page_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      if (cfg_we) begin
        margin_r <= cfg_glyph_margin;
      end
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      row_h_r     <= row_h_nxt;
      page_r      <= page_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= res_status;
      out_page_r   <= res_page;
      out_x_r      <= res_x;
      out_y_r      <= res_y;
      out_w_r      <= res_w;
      out_h_r      <= res_h;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_page_index = out_page_r;
  assign out_pos_x      = out_x_r;
  assign out_pos_y      = out_y_r;
  assign out_out_width  = out_w_r;
  assign out_out_height = out_h_r;

endmodule

// ===== rtl/core/gasa_checker.sv =====
// Port-level checker for the glyph atlas shelf allocator, with its bind statement.
// Depends on gasa_pkg and on the port names of glyph_atlas_shelf_allocator_unit.
module gasa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [gasa_pkg::PAGE_W-1:0]   out_page_index,
  input logic [gasa_pkg::POS_W-1:0]    out_pos_x,
  input logic [gasa_pkg::POS_W-1:0]    out_pos_y,
  input logic [gasa_pkg::DIM_W-1:0]    out_out_width,
  input logic [gasa_pkg::DIM_W-1:0]    out_out_height
);
  import gasa_pkg::*;

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_page_index)
      && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_out_width) && $stable(out_out_height))
    else $error("stalled result beat changed");

  // Requests are taken one at a time: no beat is accepted right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in the lookup cycle");

  // Failed requests report all-zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_TOO_LARGE || out_status == STAT_EXHAUSTED)
      |-> out_page_index == '0 && out_pos_x == '0 && out_pos_y == '0
      && out_out_width == '0 && out_out_height == '0)
    else $error("failure result carries nonzero fields");

endmodule

bind glyph_atlas_shelf_allocator_unit gasa_checker u_gasa_checker (.*);

// ===== sim/glyph_atlas_shelf_allocator_unit_tb.sv =====
// Self-checking testbench for the glyph atlas shelf allocator.
// Drives request beats, predicts every result beat and compares field by field.
// Depends on gasa_pkg and glyph_atlas_shelf_allocator_unit.
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_unit_tb;
  import gasa_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int TALL_ITEMS      = 60;
  localparam int TAIL_ITEMS      = 200;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_PRINTED     = 40;

  // One result beat as the block reports it.
  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] page;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
  } glyph_result_t;

  // One row of the directed table; a margin write may precede the request.
  typedef struct packed {
    logic                new_margin;
    logic [MARGIN_W-1:0] margin;
    logic [CODE_W-1:0]   code;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic                typed;
    glyph_result_t       want;
  } atlas_step_t;

  localparam glyph_result_t UNTYPED  = '0;
  localparam glyph_result_t REJECTED = '{STAT_TOO_LARGE, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0};
  localparam glyph_result_t A_PLACED = '{STAT_PLACED, 3'd0, 10'd2, 10'd2, 10'd10, 10'd12};
  localparam glyph_result_t A_HIT    = '{STAT_HIT, 3'd0, 10'd2, 10'd2, 10'd10, 10'd12};

  localparam int N_STEPS = 18;
  localparam atlas_step_t DIRECTED_STEPS [N_STEPS] = '{
    '{1'b0, 4'd0,  16'h0041, 10'd10,   10'd12,   1'b1, A_PLACED},
    '{1'b0, 4'd0,  16'h0041, 10'd0,    10'd0,    1'b1, A_HIT},
    '{1'b0, 4'd0,  16'hFFFF, 10'd1023, 10'd1023, 1'b1, REJECTED},
    '{1'b0, 4'd0,  16'h0000, 10'd0,    10'd0,    1'b1,
      '{STAT_PLACED, 3'd0, 10'd14, 10'd2, 10'd0, 10'd0}},
    '{1'b0, 4'd0,  16'h8000, 10'd1021, 10'd5,    1'b1, REJECTED},
    '{1'b0, 4'd0,  16'h8001, 10'd5,    10'd1021, 1'b1, REJECTED},
    '{1'b0, 4'd0,  16'h7FFF, 10'd1020, 10'd3,    1'b0, UNTYPED},
    '{1'b0, 4'd0,  16'h5555, 10'd7,    10'd9,    1'b0, UNTYPED},
    '{1'b0, 4'd0,  16'hAAAA, 10'd0,    10'd1020, 1'b1,
      '{STAT_PLACED, 3'd1, 10'd2, 10'd2, 10'd0, 10'd1020}},
    '{1'b0, 4'd0,  16'h0041, 10'd5,    10'd5,    1'b1, A_HIT},
    '{1'b0, 4'd0,  16'hAAAA, 10'd1023, 10'd0,    1'b1,
      '{STAT_HIT, 3'd1, 10'd2, 10'd2, 10'd0, 10'd1020}},
    '{1'b0, 4'd0,  16'h1234, 10'd512,  10'd256,  1'b0, UNTYPED},
    '{1'b0, 4'd0,  16'h0100, 10'd1,    10'd1,    1'b0, UNTYPED},
    '{1'b1, 4'd0,  16'h00FF, 10'd1023, 10'd0,    1'b0, UNTYPED},
    '{1'b1, 4'd15, 16'h2000, 10'd995,  10'd0,    1'b1, REJECTED},
    '{1'b0, 4'd0,  16'h2001, 10'd994,  10'd1,    1'b0, UNTYPED},
    '{1'b0, 4'd0,  16'h2000, 10'd1,    10'd1,    1'b0, UNTYPED},
    '{1'b1, 4'd2,  16'h0041, 10'd0,    10'd0,    1'b1, A_HIT}
  };

  // Margin of each random phase; a negative entry picks one at random.
  localparam int PHASE_MARGIN [6] = '{0, 15, -1, 7, -1, 2};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CODE_W-1:0]   in_char_code;
  logic [DIM_W-1:0]    in_glyph_width;
  logic [DIM_W-1:0]    in_glyph_height;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic [PAGE_W-1:0]   out_page_index;
  logic [POS_W-1:0]    out_pos_x;
  logic [POS_W-1:0]    out_pos_y;
  logic [DIM_W-1:0]    out_out_width;
  logic [DIM_W-1:0]    out_out_height;
  logic                cfg_we;
  logic [MARGIN_W-1:0] cfg_glyph_margin;

  // Shadow of the atlas: cached glyphs, packing cursor and margin.
  glyph_result_t     atlas_cache [logic [CODE_W-1:0]];
  int unsigned       cur_x      = 2;
  int unsigned       cur_y      = 2;
  int unsigned       cur_row_h  = 2;
  int unsigned       cur_page   = 0;
  int unsigned       margin_px  = 2;

  glyph_result_t     pending_glyph_results [$];
  logic [CODE_W-1:0] used_codes [$];
  int unsigned       status_tally [4];
  int unsigned       requests_sent;
  int unsigned       margin_writes;
  int unsigned       error_count;
  bit                tx_idle_on;
  bit                rx_idle_on;
  int                rx_hold_cycles;

  glyph_atlas_shelf_allocator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_page_index  (out_page_index),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_out_width   (out_out_width),
    .out_out_height  (out_out_height),
    .cfg_we          (cfg_we),
    .cfg_glyph_margin(cfg_glyph_margin)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Looks the code up in the shadow cache, or places the glyph by shelf packing
  // and records it. Failed placements leave the shadow state untouched.
  function automatic glyph_result_t place_or_lookup_glyph(logic [CODE_W-1:0] code,
                                                           logic [DIM_W-1:0] gw,
                                                           logic [DIM_W-1:0] gh);
    glyph_result_t res;
    int unsigned   cell_w;
    int unsigned   cell_h;
    int unsigned   x;
    int unsigned   y;
    int unsigned   row_h;
    int unsigned   page;
    res = '0;
    res.status = STAT_TOO_LARGE;
    if (int'(code) >= CODE_SPACE) return res;
    if (atlas_cache.exists(code)) begin
      res = atlas_cache[code];
      res.status = STAT_HIT;
      return res;
    end
    cell_w = gw + margin_px;
    cell_h = gh + margin_px;
    if (margin_px + cell_w > TEXTURE_SIZE || margin_px + cell_h > TEXTURE_SIZE) return res;
    x     = cur_x;
    y     = cur_y;
    row_h = cur_row_h;
    page  = cur_page;
    // Past the right edge: start a new row under the current one.
    if (x + cell_w > TEXTURE_SIZE) begin
      x     = margin_px;
      y     = y + row_h;
      row_h = margin_px;
    end
    // Past the bottom: open the next page, unless none is left.
    if (y + cell_h > TEXTURE_SIZE) begin
      if (page + 1 >= MAX_PAGES) begin
        res.status = STAT_EXHAUSTED;
        return res;
      end
      page  = page + 1;
      x     = margin_px;
      y     = margin_px;
      row_h = margin_px;
    end
    cur_page  = page;
    cur_x     = x + cell_w;
    cur_y     = y;
    cur_row_h = (cell_h > row_h) ? cell_h : row_h;
    res.status = STAT_PLACED;
    res.page   = page[PAGE_W-1:0];
    res.x      = x[POS_W-1:0];
    res.y      = y[POS_W-1:0];
    res.w      = gw;
    res.h      = gh;
    atlas_cache[code] = res;
    return res;
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Compares one result beat with the oldest pending expectation.
  task automatic compare_glyph_beat();
    glyph_result_t want;
    if (pending_glyph_results.size() == 0) begin
      flag_mismatch("status of a result beat with nothing pending", out_status, 0);
      return;
    end
    want = pending_glyph_results.pop_front();
    if (out_status !== want.status)     flag_mismatch("status", out_status, want.status);
    if (out_page_index !== want.page)   flag_mismatch("page_index", out_page_index, want.page);
    if (out_pos_x !== want.x)           flag_mismatch("pos_x", out_pos_x, want.x);
    if (out_pos_y !== want.y)           flag_mismatch("pos_y", out_pos_y, want.y);
    if (out_out_width !== want.w)       flag_mismatch("out_width", out_out_width, want.w);
    if (out_out_height !== want.h)      flag_mismatch("out_height", out_out_height, want.h);
  endtask

  // Result beats are taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) compare_glyph_beat();
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_ready = 1'b0;
        for (held = 0; held < rx_hold_cycles; held++) @(negedge clk);
        rx_hold_cycles = 0;
      end
      out_ready = !(rx_idle_on && ($urandom_range(0, 99) < 33));
    end
  end

  // Offers one request beat, holds it until accepted, then records the prediction.
  task automatic offer_request(input logic [CODE_W-1:0] code, input logic [DIM_W-1:0] gw,
                               input logic [DIM_W-1:0] gh, input bit typed,
                               input glyph_result_t want);
    glyph_result_t predicted;
    @(negedge clk);
    while (tx_idle_on && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_char_code    = code;
    in_glyph_width  = gw;
    in_glyph_height = gh;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = place_or_lookup_glyph(code, gw, gh);
    if (typed && predicted !== want) flag_mismatch("directed row vs prediction", predicted, want);
    pending_glyph_results = {pending_glyph_results, (typed ? want : predicted)};
    status_tally[int'(predicted.status)]++;
    requests_sent++;
  endtask

  // Writes the margin once the block has drained and settled.
  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_glyph_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_glyph_margin = value;
    cfg_we           = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    margin_px = value;
    margin_writes++;
  endtask

  // Draws a random request: outside tall mode about a third revisit earlier codes and sizes are mostly small.
  task automatic pick_glyph(input bit tall, output logic [CODE_W-1:0] code,
                            output logic [DIM_W-1:0] gw, output logic [DIM_W-1:0] gh);
    int unsigned roll;
    int unsigned top;
    top = TEXTURE_SIZE - 2 * margin_px;
    if (top > 1023) top = 1023;
    roll = $urandom_range(0, 99);
    if (!tall && used_codes.size() != 0 && roll < 35) begin
      code = used_codes[$urandom_range(0, used_codes.size() - 1)];
    end else begin
      code = CODE_W'($urandom);
      used_codes = {used_codes, code};
      if (used_codes.size() > 200) void'(used_codes.pop_front());
    end
    roll = $urandom_range(0, 99);
    if (tall) begin
      gw = DIM_W'($urandom_range(300, top));
      gh = DIM_W'($urandom_range(600, top));
    end else if (roll < 3) begin
      gw = DIM_W'($urandom_range(0, 1023));
      gh = DIM_W'($urandom_range(0, 31));
    end else if (roll < 4) begin
      gw = DIM_W'($urandom_range(0, 1023));
      gh = DIM_W'($urandom_range(0, 1023));
    end else begin
      gw = DIM_W'($urandom_range(0, 31));
      gh = DIM_W'($urandom_range(0, 31));
    end
  endtask

  // Main sequence: reset, directed table, random phases, page fill, wrap-up.
  initial begin : stimulus
    logic [CODE_W-1:0] code;
    logic [DIM_W-1:0]  gw;
    logic [DIM_W-1:0]  gh;
    int                pm;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_char_code     = '0;
    in_glyph_width   = '0;
    in_glyph_height  = '0;
    cfg_we           = 1'b0;
    cfg_glyph_margin = MARGIN_RST;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    rx_hold_cycles   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: field extremes, hits, rejections, wraps and margin changes.
    for (int r = 0; r < N_STEPS; r++) begin
      if (DIRECTED_STEPS[r].new_margin) write_margin(DIRECTED_STEPS[r].margin);
      offer_request(DIRECTED_STEPS[r].code, DIRECTED_STEPS[r].w, DIRECTED_STEPS[r].h,
                    DIRECTED_STEPS[r].typed, DIRECTED_STEPS[r].want);
    end

    // Random phases at several margins; one with a long hold-off, one without idling.
    for (int p = 0; p < 6; p++) begin
      pm = PHASE_MARGIN[p];
      write_margin(MARGIN_W'(pm < 0 ? $urandom_range(1, 14) : pm));
      tx_idle_on = (p != 3);
      rx_idle_on = (p != 3);
      if (p == 2) rx_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick_glyph(1'b0, code, gw, gh);
        offer_request(code, gw, gh, 1'b0, UNTYPED);
      end
    end

    // Tall glyphs use up the remaining pages, then small ones probe what is left.
    write_margin(MARGIN_W'($urandom_range(0, 15)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < TALL_ITEMS + TAIL_ITEMS; i++) begin
      pick_glyph(i < TALL_ITEMS, code, gw, gh);
      offer_request(code, gw, gh, 1'b0, UNTYPED);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_glyph_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests: %0d hits, %0d placed, %0d too large, %0d out of pages.",
             requests_sent, status_tally[STAT_HIT], status_tally[STAT_PLACED],
             status_tally[STAT_TOO_LARGE], status_tally[STAT_EXHAUSTED]);
    $display("It used %0d margin settings and reached atlas page %0d.",
             margin_writes, cur_page);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: covers the table clearing pass after reset with a wide margin.
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gasa_pkg.sv
rtl/core/glyph_atlas_shelf_allocator_unit.sv
rtl/core/gasa_checker.sv
sim/glyph_atlas_shelf_allocator_unit_tb.sv
